// ===== rtl/aik_pkg.sv =====
// Shared types, constants and tables for the arm inverse kinematics block.
// Used by every module in rtl except aik_sqrt; depends on nothing.
package aik_pkg;

  localparam int unsigned AIK_ITER_DEF = 16;
  localparam int unsigned ANG_W = 28;
  localparam int unsigned COR_IN_W = 34;
  localparam int unsigned COR_W = 56;
  localparam int unsigned COR_SCALE = 20;

  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 * 65536);
  localparam logic [15:0] ANG_MAX = 16'd46080;
  localparam logic [15:0] ANG_HOLD_RST = 16'd23040;

  localparam logic [2:0] REG_X_OFF = 3'd0;
  localparam logic [2:0] REG_Y_OFF = 3'd1;
  localparam logic [2:0] REG_Z_OFF = 3'd2;
  localparam logic [2:0] REG_UPPER = 3'd3;
  localparam logic [2:0] REG_LOWER = 3'd4;
  localparam logic [2:0] REG_RMAX = 3'd5;
  localparam logic [2:0] REG_RMIN = 3'd6;
  localparam logic [2:0] REG_PMIN = 3'd7;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
  } in_word_t;

  typedef struct packed {
    logic [15:0] base_angle;
    logic [15:0] shoulder_angle;
    logic [15:0] elbow_angle;
    logic        in_reach;
  } out_word_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_XX, MUL_YY, MUL_ZZ, MUL_RMAX, MUL_RMIN, MUL_PMIN,
    MUL_UP, MUL_LO, MUL_UPTOT, MUL_LOUP, MUL_DEL, MUL_MAG
  } mul_op_e;

  typedef enum logic [3:0] {
    ALU_NONE, ALU_PLAN, ALU_TOT, ALU_CHK, ALU_ELEV, ALU_BASE, ALU_LD_SH,
    ALU_LD_EL, ALU_LA_CLAMP, ALU_LA, ALU_SH, ALU_EL
  } alu_op_e;

  typedef enum logic {SQ_PLAN, SQ_LA} sqrt_src_e;

  typedef enum logic [1:0] {COR_ELEV, COR_BASE, COR_LA} cor_src_e;

  typedef struct packed {
    logic      load_in;
    mul_op_e   mul_op;
    alu_op_e   alu_op;
    logic      sqrt_start;
    sqrt_src_e sqrt_src;
    logic      cor_start;
    cor_src_e  cor_src;
    logic      commit;
  } aik_cmd_t;

  typedef struct packed {
    logic ok;
    logic la_clamp;
    logic sqrt_busy;
    logic cor_busy;
  } aik_status_t;

  // Arctangent of 2^-i in 2^-16 degree, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_entry(logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0: v = ANG_W'(2949120);
      5'd1: v = ANG_W'(1740967);
      5'd2: v = ANG_W'(919879);
      5'd3: v = ANG_W'(466945);
      5'd4: v = ANG_W'(234379);
      5'd5: v = ANG_W'(117304);
      5'd6: v = ANG_W'(58666);
      5'd7: v = ANG_W'(29335);
      5'd8: v = ANG_W'(14668);
      5'd9: v = ANG_W'(7334);
      5'd10: v = ANG_W'(3667);
      5'd11: v = ANG_W'(1833);
      5'd12: v = ANG_W'(917);
      5'd13: v = ANG_W'(458);
      5'd14: v = ANG_W'(229);
      5'd15: v = ANG_W'(115);
      5'd16: v = ANG_W'(57);
      5'd17: v = ANG_W'(29);
      5'd18: v = ANG_W'(14);
      5'd19: v = ANG_W'(7);
      5'd20: v = ANG_W'(4);
      5'd21: v = ANG_W'(2);
      5'd22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/aik_sqrt.sv =====
// Iterative floor square root of a 64-bit value, two radicand bits per cycle.
// Depends on aik_pkg only by convention; uses no package items.
module aik_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        busy_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q, rem_d;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [35:0] rem_sh, trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    ge = (rem_sh >= trial);
    rem_d = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= rad_i;
      rem_q <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      rem_q <= rem_d;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// ===== rtl/aik_cordic.sv =====
// Vectoring CORDIC for atan2, one rotation step per cycle.
// Depends on aik_pkg for widths, angle constants and the arctangent table.
module aik_cordic import aik_pkg::*; #(
  parameter int unsigned ITER = AIK_ITER_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [COR_IN_W-1:0] y_i,
  input  logic signed [COR_IN_W-1:0] x_i,
  output logic                       busy_o,
  output logic signed [ANG_W-1:0]    angle_o
);

  localparam int unsigned CNT_W = $clog2(ITER);

  logic signed [COR_W-1:0] x_q, y_q, xe, ye, xn, yn, dx, dy;
  logic signed [ANG_W-1:0] acc_q, base_q, step_ang;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q;
  logic                    neg;

  always_comb begin
    xe = COR_W'(x_i);
    ye = COR_W'(y_i);
    neg = x_i < 0;
    xn = neg ? -xe : xe;
    yn = neg ? -ye : ye;
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    step_ang = atan_entry(5'(cnt_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= (x_i != '0) || (y_i != '0);
      cnt_q <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ITER - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q <= xn <<< COR_SCALE;
      y_q <= yn <<< COR_SCALE;
      if ((x_i == '0 && y_i == '0) || !neg) begin
        base_q <= '0;
      end else begin
        base_q <= (y_i >= 0) ? DEG180 : -DEG180;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        acc_q <= acc_q + step_ang;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        acc_q <= acc_q - step_ang;
      end
    end
  end

  assign busy_o = busy_q;
  assign angle_o = base_q + acc_q;

endmodule

// ===== rtl/aik_dp.sv =====
// Datapath: configuration registers, shared multiplier, square root and CORDIC
// units, angle registers and the output word. Depends on aik_pkg.
module aik_dp import aik_pkg::*; #(
  parameter int unsigned ITER = AIK_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_word_t    in_word_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  aik_cmd_t    cmd_i,
  output aik_status_t status_o,
  output out_word_t   out_word_o
);

  logic signed [15:0] x_off_q, y_off_q, z_off_q;
  logic [14:0] up_q, lo_q;
  logic [15:0] rmax_q, rmin_q, pmin_q;

  logic signed [16:0] xs_q, ys_q, zs_q;
  logic [32:0] xsq_q, ysq_q, zsq_q;
  logic [33:0] plan_q, tot_q;
  logic [31:0] rmaxsq_q, rminsq_q, pminsq_q;
  logic [29:0] upsq_q, losq_q;
  logic        ok_q;
  logic signed [35:0] n_q, n_sh, n_el;
  logic [35:0] nmag;
  logic [63:0] d2_q, prod_q;
  logic signed [ANG_W-1:0] elev_q, base_q, la_q, sh_q, el_q;
  logic [15:0] held_base_q, held_sh_q, held_el_q;
  out_word_t out_q;

  logic [16:0] xmag, ymag, zmag;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sqrt_busy, cor_busy;
  logic [31:0] root;
  logic [63:0] sq_rad;
  logic signed [COR_IN_W-1:0] cor_y, cor_x;
  logic signed [ANG_W-1:0] cor_ang;
  logic [15:0] base_out, sh_out, el_out;

  function automatic logic [15:0] to_out(logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] s;
    logic signed [ANG_W-9:0] r;
    s = a + ANG_W'(128);
    r = (ANG_W-8)'(s >>> 8);
    if (r < 0) begin
      return 16'd0;
    end else if (r > $signed({{(ANG_W-24){1'b0}}, ANG_MAX})) begin
      return ANG_MAX;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q <= -16'sd896;
      y_off_q <= 16'sd0;
      z_off_q <= -16'sd1587;
      up_q <= 15'd3149;
      lo_q <= 15'd3072;
      rmax_q <= 16'd6144;
      rmin_q <= 16'd1024;
      pmin_q <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_OFF: x_off_q <= cfg_data_i;
        REG_Y_OFF: y_off_q <= cfg_data_i;
        REG_Z_OFF: z_off_q <= cfg_data_i;
        REG_UPPER: up_q <= cfg_data_i[14:0];
        REG_LOWER: lo_q <= cfg_data_i[14:0];
        REG_RMAX: rmax_q <= cfg_data_i;
        REG_RMIN: rmin_q <= cfg_data_i;
        REG_PMIN: pmin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    xmag = xs_q[16] ? 17'(-xs_q) : 17'(xs_q);
    ymag = ys_q[16] ? 17'(-ys_q) : 17'(ys_q);
    zmag = zs_q[16] ? 17'(-zs_q) : 17'(zs_q);
    nmag = n_q[35] ? 36'(-n_q) : 36'(n_q);
    n_sh = $signed(36'(upsq_q)) + $signed(36'(tot_q)) - $signed(36'(losq_q));
    n_el = $signed(36'(losq_q)) + $signed(36'(upsq_q)) - $signed(36'(tot_q));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      MUL_XX: begin mul_a = 32'(xmag); mul_b = 32'(xmag); end
      MUL_YY: begin mul_a = 32'(ymag); mul_b = 32'(ymag); end
      MUL_ZZ: begin mul_a = 32'(zmag); mul_b = 32'(zmag); end
      MUL_RMAX: begin mul_a = 32'(rmax_q); mul_b = 32'(rmax_q); end
      MUL_RMIN: begin mul_a = 32'(rmin_q); mul_b = 32'(rmin_q); end
      MUL_PMIN: begin mul_a = 32'(pmin_q); mul_b = 32'(pmin_q); end
      MUL_UP: begin mul_a = 32'(up_q); mul_b = 32'(up_q); end
      MUL_LO: begin mul_a = 32'(lo_q); mul_b = 32'(lo_q); end
      MUL_UPTOT: begin mul_a = 32'(upsq_q); mul_b = tot_q[31:0]; end
      MUL_LOUP: begin mul_a = 32'(lo_q); mul_b = 32'(up_q); end
      MUL_DEL: begin
        mul_a = {prod_q[30:0], 1'b0};
        mul_b = {prod_q[30:0], 1'b0};
      end
      MUL_MAG: begin mul_a = nmag[31:0]; mul_b = nmag[31:0]; end
      default: ;
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  assign sq_rad = (cmd_i.sqrt_src == SQ_PLAN) ? {14'd0, plan_q, 16'd0} : (d2_q - prod_q);

  always_comb begin
    unique case (cmd_i.cor_src)
      COR_ELEV: begin
        cor_y = {{9{zs_q[16]}}, zs_q, 8'd0};
        cor_x = {9'd0, root[24:0]};
      end
      COR_BASE: begin
        cor_y = COR_IN_W'(ys_q);
        cor_x = COR_IN_W'(xs_q);
      end
      default: begin
        cor_y = {2'b00, root};
        cor_x = n_q[COR_IN_W-1:0];
      end
    endcase
  end

  aik_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .rad_i  (sq_rad),
    .busy_o (sqrt_busy),
    .root_o (root)
  );

  aik_cordic #(.ITER(ITER)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cor_start),
    .y_i    (cor_y),
    .x_i    (cor_x),
    .busy_o (cor_busy),
    .angle_o(cor_ang)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xs_q <= $signed({in_word_i.target_x[15], in_word_i.target_x}) +
              $signed({x_off_q[15], x_off_q});
      ys_q <= $signed({in_word_i.target_y[15], in_word_i.target_y}) +
              $signed({y_off_q[15], y_off_q});
      zs_q <= $signed({in_word_i.target_z[15], in_word_i.target_z}) +
              $signed({z_off_q[15], z_off_q});
    end
    unique case (cmd_i.mul_op)
      MUL_XX: xsq_q <= mul_p[32:0];
      MUL_YY: ysq_q <= mul_p[32:0];
      MUL_ZZ: zsq_q <= mul_p[32:0];
      MUL_RMAX: rmaxsq_q <= mul_p[31:0];
      MUL_RMIN: rminsq_q <= mul_p[31:0];
      MUL_PMIN: pminsq_q <= mul_p[31:0];
      MUL_UP: upsq_q <= mul_p[29:0];
      MUL_LO: losq_q <= mul_p[29:0];
      MUL_UPTOT, MUL_LOUP, MUL_DEL, MUL_MAG: prod_q <= mul_p;
      default: ;
    endcase
    unique case (cmd_i.alu_op)
      ALU_PLAN: plan_q <= 34'(xsq_q) + 34'(ysq_q);
      ALU_TOT: tot_q <= plan_q + 34'(zsq_q);
      ALU_CHK: ok_q <= (tot_q <= 34'(rmaxsq_q)) && (tot_q >= 34'(rminsq_q)) &&
                       (plan_q >= 34'(pminsq_q));
      ALU_ELEV: elev_q <= cor_ang;
      ALU_BASE: base_q <= cor_ang + DEG90;
      ALU_LD_SH: begin
        n_q <= n_sh;
        d2_q <= {prod_q[61:0], 2'b00};
      end
      ALU_LD_EL: begin
        n_q <= n_el;
        d2_q <= prod_q;
      end
      ALU_LA_CLAMP: la_q <= n_q[35] ? DEG180 : '0;
      ALU_LA: la_q <= cor_ang;
      ALU_SH: sh_q <= la_q + elev_q;
      ALU_EL: el_q <= DEG180 - la_q;
      default: ;
    endcase
  end

  assign base_out = to_out(base_q);
  assign sh_out = to_out(sh_q);
  assign el_out = to_out(el_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_base_q <= ANG_HOLD_RST;
      held_sh_q <= ANG_HOLD_RST;
      held_el_q <= ANG_HOLD_RST;
    end else if (cmd_i.commit && ok_q) begin
      held_base_q <= base_out;
      held_sh_q <= sh_out;
      held_el_q <= el_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.in_reach <= ok_q;
      out_q.base_angle <= ok_q ? base_out : held_base_q;
      out_q.shoulder_angle <= ok_q ? sh_out : held_sh_q;
      out_q.elbow_angle <= ok_q ? el_out : held_el_q;
    end
  end

  assign status_o.ok = ok_q;
  assign status_o.la_clamp = (nmag[35:32] != 4'd0) || (prod_q >= d2_q);
  assign status_o.sqrt_busy = sqrt_busy;
  assign status_o.cor_busy = cor_busy;
  assign out_word_o = out_q;

endmodule

// ===== rtl/aik_ctrl.sv =====
// Controller state machine that sequences the datapath for one target word.
// Depends on aik_pkg for the command and status types.
module aik_ctrl import aik_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  aik_status_t status_i,
  output aik_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_RMAX, ST_SQ_RMIN, ST_SQ_PMIN,
    ST_SQ_UP, ST_SQ_LO, ST_PLAN, ST_TOT, ST_CHECK, ST_DECIDE,
    ST_PL_START, ST_PL_WAIT, ST_EV_START, ST_EV_WAIT, ST_EV_STORE,
    ST_BS_START, ST_BS_WAIT, ST_BS_STORE, ST_M_UPTOT, ST_LD_SH,
    ST_LA_MAG, ST_LA_CMP, ST_LA_CLAMP, ST_LA_SQ_START, ST_LA_SQ_WAIT,
    ST_LA_COR_START, ST_LA_COR_WAIT, ST_LA_STORE, ST_LA_END,
    ST_ST_SH, ST_M_LOUP, ST_M_DEL, ST_LD_EL, ST_ST_EL, ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   elbow_q, elbow_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    elbow_d = elbow_q;
    cmd_o = '0;
    cmd_o.mul_op = MUL_NONE;
    cmd_o.alu_op = ALU_NONE;
    cmd_o.sqrt_src = SQ_PLAN;
    cmd_o.cor_src = COR_ELEV;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load_in = 1'b1;
        state_d = ST_SQ_X;
      end
      ST_SQ_X: begin cmd_o.mul_op = MUL_XX; state_d = ST_SQ_Y; end
      ST_SQ_Y: begin cmd_o.mul_op = MUL_YY; state_d = ST_SQ_Z; end
      ST_SQ_Z: begin cmd_o.mul_op = MUL_ZZ; state_d = ST_SQ_RMAX; end
      ST_SQ_RMAX: begin cmd_o.mul_op = MUL_RMAX; state_d = ST_SQ_RMIN; end
      ST_SQ_RMIN: begin cmd_o.mul_op = MUL_RMIN; state_d = ST_SQ_PMIN; end
      ST_SQ_PMIN: begin cmd_o.mul_op = MUL_PMIN; state_d = ST_SQ_UP; end
      ST_SQ_UP: begin cmd_o.mul_op = MUL_UP; state_d = ST_SQ_LO; end
      ST_SQ_LO: begin cmd_o.mul_op = MUL_LO; state_d = ST_PLAN; end
      ST_PLAN: begin cmd_o.alu_op = ALU_PLAN; state_d = ST_TOT; end
      ST_TOT: begin cmd_o.alu_op = ALU_TOT; state_d = ST_CHECK; end
      ST_CHECK: begin cmd_o.alu_op = ALU_CHK; state_d = ST_DECIDE; end
      ST_DECIDE: state_d = status_i.ok ? ST_PL_START : ST_FINISH;
      ST_PL_START: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_src = SQ_PLAN;
        state_d = ST_PL_WAIT;
      end
      ST_PL_WAIT: if (!status_i.sqrt_busy) state_d = ST_EV_START;
      ST_EV_START: begin
        cmd_o.cor_start = 1'b1;
        cmd_o.cor_src = COR_ELEV;
        state_d = ST_EV_WAIT;
      end
      ST_EV_WAIT: if (!status_i.cor_busy) state_d = ST_EV_STORE;
      ST_EV_STORE: begin cmd_o.alu_op = ALU_ELEV; state_d = ST_BS_START; end
      ST_BS_START: begin
        cmd_o.cor_start = 1'b1;
        cmd_o.cor_src = COR_BASE;
        state_d = ST_BS_WAIT;
      end
      ST_BS_WAIT: if (!status_i.cor_busy) state_d = ST_BS_STORE;
      ST_BS_STORE: begin cmd_o.alu_op = ALU_BASE; state_d = ST_M_UPTOT; end
      ST_M_UPTOT: begin cmd_o.mul_op = MUL_UPTOT; state_d = ST_LD_SH; end
      ST_LD_SH: begin
        cmd_o.alu_op = ALU_LD_SH;
        elbow_d = 1'b0;
        state_d = ST_LA_MAG;
      end
      ST_LA_MAG: begin cmd_o.mul_op = MUL_MAG; state_d = ST_LA_CMP; end
      ST_LA_CMP: state_d = status_i.la_clamp ? ST_LA_CLAMP : ST_LA_SQ_START;
      ST_LA_CLAMP: begin cmd_o.alu_op = ALU_LA_CLAMP; state_d = ST_LA_END; end
      ST_LA_SQ_START: begin
        cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_src = SQ_LA;
        state_d = ST_LA_SQ_WAIT;
      end
      ST_LA_SQ_WAIT: if (!status_i.sqrt_busy) state_d = ST_LA_COR_START;
      ST_LA_COR_START: begin
        cmd_o.cor_start = 1'b1;
        cmd_o.cor_src = COR_LA;
        state_d = ST_LA_COR_WAIT;
      end
      ST_LA_COR_WAIT: if (!status_i.cor_busy) state_d = ST_LA_STORE;
      ST_LA_STORE: begin cmd_o.alu_op = ALU_LA; state_d = ST_LA_END; end
      ST_LA_END: state_d = elbow_q ? ST_ST_EL : ST_ST_SH;
      ST_ST_SH: begin cmd_o.alu_op = ALU_SH; state_d = ST_M_LOUP; end
      ST_M_LOUP: begin cmd_o.mul_op = MUL_LOUP; state_d = ST_M_DEL; end
      ST_M_DEL: begin cmd_o.mul_op = MUL_DEL; state_d = ST_LD_EL; end
      ST_LD_EL: begin
        cmd_o.alu_op = ALU_LD_EL;
        elbow_d = 1'b1;
        state_d = ST_LA_MAG;
      end
      ST_ST_EL: begin cmd_o.alu_op = ALU_EL; state_d = ST_FINISH; end
      ST_FINISH: if (out_free) begin
        cmd_o.commit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      elbow_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      elbow_q <= elbow_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed word not presented");
  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sqrt_start |-> !status_i.sqrt_busy)
    else $error("square root started while busy");
  a_cor_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cor_start |-> !status_i.cor_busy)
    else $error("CORDIC started while busy");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted during work");

endmodule

// ===== rtl/arm_inverse_kinematics.sv =====
// Top level of the arm inverse kinematics block.
// Depends on aik_pkg, aik_ctrl, aik_dp, aik_sqrt and aik_cordic.
//
// A target word (x, y, z in 1/256 cm) enters on the in channel (valid and
// ready); one result word (base, shoulder and elbow angles in 1/256 degree
// and an in-reach flag) leaves on the out channel for every target word.
// One word is worked on at a time, and in ready is high only while idle.
// A target out of reach goes from the reach check straight to the commit;
// one in reach also runs the elevation and base CORDICs and, for each acos
// argument that is not clamped, a square root and a CORDIC. The shared
// square root retires two radicand bits per cycle and the shared CORDIC
// takes one iteration per cycle, used three and four times. The next word
// is accepted once the block is back in idle after the commit. The result
// is held in an output register, so the next word is accepted while a
// result waits; if the receiver stalls, the block finishes that next word
// and then waits. Reset restores the register defaults, sets the held
// angles to 90 degrees and empties the output. Configuration writes take
// effect at once and are to be issued only while the block is idle.
module arm_inverse_kinematics import aik_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = AIK_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  aik_cmd_t    cmd;
  aik_status_t status;

  aik_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aik_dp #(.ITER(CORDIC_ITERATIONS)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_word_i (in_word_i),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd_i     (cmd),
    .status_o  (status),
    .out_word_o(out_word_o)
  );

endmodule

// ===== tb/sv/arm_inverse_kinematics_tb.sv =====
// Self-checking testbench for arm_inverse_kinematics: directed table plus random targets
// under several register settings, checked against a fixed-point predictor of the angles.
// Depends on aik_pkg and the arm_inverse_kinematics RTL.
module arm_inverse_kinematics_tb;
  import aik_pkg::*;

  localparam int unsigned ITERS = 16;
  localparam longint ANG180 = 64'sd180 * 65536;
  localparam longint ANG90 = 64'sd90 * 65536;
  localparam int RANDOM_WORDS = 1900;
  localparam int PHASES = 9;

  localparam int SET_DEFAULT = 0;
  localparam int SET_OPEN = 1;
  localparam int SET_TINY_UPPER = 2;
  localparam int SET_MIN_OFFSETS = 3;
  localparam int SET_CLOSED = 4;
  localparam int SET_RANDOM = 5;

  localparam longint ARCTAN_2I [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct {
    int        setting;
    logic      typed;
    int        tx, ty, tz;
    out_word_t angles;
  } target_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  logic [15:0] arm_regs [8];
  logic [15:0] hold_base, hold_shoulder, hold_elbow;
  out_word_t   angle_queue [$];
  int          tx_idle_pct, rx_idle_pct;
  int          mismatches = 0, words_sent = 0, words_checked = 0, in_reach_seen = 0;

  arm_inverse_kinematics #(.CORDIC_ITERATIONS(ITERS)) u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("arm_inverse_kinematics_tb NOT OK");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint acc = 0;
    longint quad = 0;
    longint dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      quad = (y >= 0) ? ANG180 : -ANG180;
      x = -x;
      y = -y;
    end
    x = x <<< 20;
    y = y <<< 20;
    for (int i = 0; i < ITERS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; acc += ARCTAN_2I[i];
      end else begin
        x -= dx; y += dy; acc -= ARCTAN_2I[i];
      end
    end
    return quad + acc;
  endfunction

  function automatic longint cosine_angle(longint n, longint unsigned d2);
    longint unsigned mag;
    longint unsigned n2;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    if (mag >= 64'h1_0000_0000) return (n >= 0) ? 0 : ANG180;
    n2 = mag * mag;
    if (n2 >= d2) return (n >= 0) ? 0 : ANG180;
    return vector_angle(longint'(floor_sqrt(d2 - n2)), n);
  endfunction

  function automatic logic [15:0] servo_units(longint a);
    longint r;
    r = (a + 128) >>> 8;
    if (r < 0) r = 0;
    if (r > 46080) r = 46080;
    return 16'(r);
  endfunction

  function automatic out_word_t solve_angles(in_word_t w);
    longint x, y, z, plan_sq, tot_sq, rmax, rmin, pmin, elev, base, n_sh, n_el;
    longint unsigned up, lo, d2_sh, d_el;
    logic ok;
    out_word_t r;
    x = longint'(w.target_x) + longint'($signed(arm_regs[REG_X_OFF]));
    y = longint'(w.target_y) + longint'($signed(arm_regs[REG_Y_OFF]));
    z = longint'(w.target_z) + longint'($signed(arm_regs[REG_Z_OFF]));
    plan_sq = x * x + y * y;
    tot_sq = plan_sq + z * z;
    rmax = longint'(arm_regs[REG_RMAX]);
    rmin = longint'(arm_regs[REG_RMIN]);
    pmin = longint'(arm_regs[REG_PMIN]);
    up = longint'(arm_regs[REG_UPPER]);
    lo = longint'(arm_regs[REG_LOWER]);
    ok = tot_sq <= rmax * rmax && tot_sq >= rmin * rmin && plan_sq >= pmin * pmin;
    if (ok) begin
      elev = vector_angle(z * 256, longint'(floor_sqrt(plan_sq << 16)));
      base = vector_angle(y, x) + ANG90;
      n_sh = longint'(up * up) + tot_sq - longint'(lo * lo);
      d2_sh = 4 * up * up * longint'(tot_sq);
      n_el = longint'(lo * lo) + longint'(up * up) - tot_sq;
      d_el = 2 * lo * up;
      hold_base = servo_units(base);
      hold_shoulder = servo_units(cosine_angle(n_sh, d2_sh) + elev);
      hold_elbow = servo_units(ANG180 - cosine_angle(n_el, d_el * d_el));
    end
    r.base_angle = hold_base;
    r.shoulder_angle = hold_shoulder;
    r.elbow_angle = hold_elbow;
    r.in_reach = ok;
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = 16'(value);
    arm_regs[idx] = (idx == REG_UPPER || idx == REG_LOWER) ? 16'(value & 16'h7FFF)
                                                           : 16'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_setting(int sel);
    int v [8];
    case (sel)
      SET_DEFAULT: v = '{-896, 0, -1587, 3149, 3072, 6144, 1024, 1024};
      SET_OPEN: v = '{0, 0, 0, 3149, 3072, 65535, 0, 0};
      SET_TINY_UPPER: v = '{0, 0, 0, 1, 32767, 65535, 0, 0};
      SET_MIN_OFFSETS: v = '{-32768, -32768, -32768, 32767, 32767, 65535, 0, 0};
      SET_CLOSED: v = '{32767, 32767, 32767, 1, 1, 65535, 65535, 65535};
      default: begin
        for (int i = 0; i < 3; i++) v[i] = $urandom_range(8000) - 4000;
        v[3] = $urandom_range(32767, 1);
        v[4] = $urandom_range(32767, 1);
        v[5] = $urandom_range(65535, 2000);
        v[6] = $urandom_range(v[5] / 4);
        v[7] = $urandom_range(v[5] / 4);
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
  endtask

  task automatic wait_drained();
    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_target(in_word_t w, logic typed, out_word_t typed_angles);
    out_word_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = solve_angles(w);
    angle_queue.push_back(typed ? typed_angles : predicted);
    words_sent++;
  endtask

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
  endfunction

  function automatic int aimed_coord(logic [2:0] off_idx);
    int lim;
    if ($urandom_range(99) < 25) return int'($signed(16'($urandom)));
    lim = (int'(arm_regs[REG_RMAX]) * 7) / 10 + 1;
    return sat16(int'($urandom_range(2 * lim)) - lim - int'($signed(arm_regs[off_idx])));
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word_o);
      end else begin
        want = angle_queue.pop_front();
        words_checked++;
        if (out_word_o.in_reach) in_reach_seen++;
        if (out_word_o.base_angle !== want.base_angle ||
            out_word_o.shoulder_angle !== want.shoulder_angle ||
            out_word_o.elbow_angle !== want.elbow_angle ||
            out_word_o.in_reach !== want.in_reach) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected base %0d shoulder %0d elbow %0d reach %0b, got %0d %0d %0d %0b",
                     words_checked, want.base_angle, want.shoulder_angle, want.elbow_angle,
                     want.in_reach, out_word_o.base_angle, out_word_o.shoulder_angle,
                     out_word_o.elbow_angle, out_word_o.in_reach);
        end
      end
    end
  end

  initial begin
    target_row_t rows [$];
    out_word_t   held_reset;
    in_word_t    w;
    int          cur_set, sel, per_phase;
    int          phase_sets [PHASES] = '{SET_DEFAULT, SET_RANDOM, SET_OPEN, SET_RANDOM,
                                         SET_MIN_OFFSETS, SET_RANDOM, SET_TINY_UPPER,
                                         SET_RANDOM, SET_CLOSED};
    held_reset = '{base_angle: ANG_HOLD_RST, shoulder_angle: ANG_HOLD_RST,
                   elbow_angle: ANG_HOLD_RST, in_reach: 1'b0};
    rows = '{
      '{SET_DEFAULT, 1'b1, 0, 0, 0, held_reset},
      '{SET_DEFAULT, 1'b1, -32768, -32768, -32768, held_reset},
      '{SET_DEFAULT, 1'b1, 32767, 32767, 32767, held_reset},
      '{SET_DEFAULT, 1'b1, 32767, -32768, 0, held_reset},
      '{SET_DEFAULT, 1'b0, 4000, 0, 3000, held_reset},
      '{SET_DEFAULT, 1'b0, 896, 3000, 1587, held_reset},
      '{SET_DEFAULT, 1'b0, 896, -3000, 1587, held_reset},
      '{SET_DEFAULT, 1'b0, -2104, 0, 1587, held_reset},
      '{SET_DEFAULT, 1'b0, -2104, -1, 1587, held_reset},
      '{SET_DEFAULT, 1'b0, 4000, 0, 6000, held_reset},
      '{SET_DEFAULT, 1'b0, 4000, 0, -3000, held_reset},
      '{SET_OPEN, 1'b0, 0, 0, 0, held_reset},
      '{SET_OPEN, 1'b0, 6221, 0, 0, held_reset},
      '{SET_OPEN, 1'b0, 20, 0, 0, held_reset},
      '{SET_TINY_UPPER, 1'b0, 5000, 0, 0, held_reset},
      '{SET_TINY_UPPER, 1'b0, 0, 32767, 100, held_reset},
      '{SET_MIN_OFFSETS, 1'b0, 32767, 32767, 32767, held_reset},
      '{SET_MIN_OFFSETS, 1'b0, 32767, 32767, 0, held_reset},
      '{SET_MIN_OFFSETS, 1'b0, -32768, -32768, -32768, held_reset},
      '{SET_CLOSED, 1'b0, -32768, -32768, -32768, held_reset},
      '{SET_CLOSED, 1'b0, 32767, 32767, 32767, held_reset}
    };
    arm_regs = '{16'hFC80, 16'h0000, 16'hF9CD, 16'd3149, 16'd3072, 16'd6144, 16'd1024,
                 16'd1024};
    hold_base = ANG_HOLD_RST;
    hold_shoulder = ANG_HOLD_RST;
    hold_elbow = ANG_HOLD_RST;
    tx_idle_pct = 20;
    rx_idle_pct = 86;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cur_set = SET_DEFAULT;
    foreach (rows[i]) begin
      if (rows[i].setting != cur_set) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        wait_drained();
        cur_set = rows[i].setting;
        load_setting(cur_set);
      end
      w.target_x = 16'(rows[i].tx);
      w.target_y = 16'(rows[i].ty);
      w.target_z = 16'(rows[i].tz);
      send_target(w, rows[i].typed, rows[i].angles);
    end

    per_phase = RANDOM_WORDS / PHASES;
    for (int p = 0; p < PHASES; p++) begin
      sel = phase_sets[p];
      case (p / 3)
        0: begin tx_idle_pct = 20; rx_idle_pct = 86; end
        1: begin tx_idle_pct = 86; rx_idle_pct = 20; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      @(negedge clk_i);
      in_valid_i = 1'b0;
      wait_drained();
      load_setting(sel);
      for (int k = 0; k < per_phase; k++) begin
        if (k == per_phase / 2) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          wait_drained();
        end
        w.target_x = 16'(aimed_coord(REG_X_OFF));
        w.target_y = 16'(aimed_coord(REG_Y_OFF));
        w.target_z = 16'(aimed_coord(REG_Z_OFF));
        send_target(w, 1'b0, held_reset);
      end
    end
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (angle_queue.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (angle_queue.size() != 0) mismatches++;

    $display("Sent %0d target words over %0d register settings; %0d results checked.",
             words_sent, PHASES + 5, words_checked);
    $display("%0d results were in reach; %0d mismatches.", in_reach_seen, mismatches);
    if (mismatches == 0) begin
      $display("arm_inverse_kinematics_tb OK");
    end else begin
      $display("arm_inverse_kinematics_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== arm_inverse_kinematics.f =====
rtl/aik_pkg.sv
rtl/aik_sqrt.sv
rtl/aik_cordic.sv
rtl/aik_dp.sv
rtl/aik_ctrl.sv
rtl/arm_inverse_kinematics.sv
tb/sv/arm_inverse_kinematics_tb.sv
